[design/xfd_pkg.sv]
// ----------------------------------------------------------------------------
// xfd_pkg: shared types and opcode helpers of the 8086 field decoder
// Holds the opcode classes, result codes, the gathered-instruction word and
// the length rules that both the byte gatherer and the field decoder use.
// ----------------------------------------------------------------------------
package xfd_pkg;

	// Longest instruction of the covered subset, in bytes.
	localparam int MAX_LEN = 6;

	// Default depth of the queue between gatherer and decoder.
	localparam int QUEUE_DEPTH_DEF = 2;

	// Width of the result word on the output stream, padded to whole bytes.
	localparam int RESULT_BITS = 52;
	localparam int OUT_BYTES_BITS = ((RESULT_BITS + 7) / 8) * 8;

	// Opcode patterns, compared under the masks given in op_kind.
	localparam logic [7:0] OP_MOV_RM  = 8'b1000_1000;
	localparam logic [7:0] OP_ADD_RM  = 8'b0000_0000;
	localparam logic [7:0] OP_SUB_RM  = 8'b0010_1000;
	localparam logic [7:0] OP_CMP_RM  = 8'b0011_1000;
	localparam logic [7:0] OP_MOV_IRM = 8'b1100_0110;
	localparam logic [7:0] OP_GRP_IRM = 8'b1000_0000;
	localparam logic [7:0] OP_MOV_IRG = 8'b1011_0000;
	localparam logic [7:0] OP_MEM_ACC = 8'b1010_0000;
	localparam logic [7:0] OP_ACC_MEM = 8'b1010_0010;
	localparam logic [7:0] OP_ADD_ACC = 8'b0000_0100;
	localparam logic [7:0] OP_SUB_ACC = 8'b0010_1100;
	localparam logic [7:0] OP_CMP_ACC = 8'b0011_1100;
	localparam logic [7:0] OP_JNE     = 8'b0111_0101;

	// Group selector values of the ModRM reg field.
	localparam logic [2:0] GRP_ADD = 3'b000;
	localparam logic [2:0] GRP_SUB = 3'b101;
	localparam logic [2:0] GRP_CMP = 3'b111;

	typedef enum logic [2:0] {
		K_UNKNOWN,
		K_RMREG,
		K_IMMRM,
		K_IMMREG,
		K_MEMACC,
		K_ACCMEM,
		K_ACCIMM,
		K_JNE
	} kind_t;

	typedef enum logic [2:0] {
		MN_UNKNOWN,
		MN_MOV,
		MN_ADD,
		MN_SUB,
		MN_CMP,
		MN_JNE
	} mnemonic_t;

	typedef enum logic [2:0] {
		FM_RM_REG,
		FM_IMM_RM,
		FM_IMM_REG,
		FM_MEM_TO_ACC,
		FM_ACC_TO_MEM,
		FM_ACC_IMM,
		FM_JUMP
	} form_t;

	typedef logic [7:0] byte_t;

	// One gathered instruction: its bytes and its length.
	typedef struct packed {
		byte_t [MAX_LEN-1:0] bytes;
		logic [2:0]          len;
	} instr_t;

	// Decoded fields, declared from the highest bit down.
	typedef struct packed {
		logic [2:0]  length;
		logic [15:0] immediate;
		logic [15:0] displacement;
		logic [2:0]  rm_field;
		logic [2:0]  reg_field;
		logic [1:0]  mode;
		logic        sign_extend;
		logic        to_reg;
		logic        wide;
		form_t       form;
		mnemonic_t   mnemonic;
	} result_t;

	// Fill state of the instruction queue.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Class of an opcode byte.
	function automatic kind_t op_kind(input byte_t op);
		byte_t hi6;
		byte_t hi7;
		hi6 = op & 8'hFC;
		hi7 = op & 8'hFE;
		priority if (hi6 == OP_MOV_RM || hi6 == OP_ADD_RM || hi6 == OP_SUB_RM ||
			hi6 == OP_CMP_RM) begin
			return K_RMREG;
		end else if (hi7 == OP_MOV_IRM || hi6 == OP_GRP_IRM) begin
			return K_IMMRM;
		end else if ((op & 8'hF0) == OP_MOV_IRG) begin
			return K_IMMREG;
		end else if (hi7 == OP_MEM_ACC) begin
			return K_MEMACC;
		end else if (hi7 == OP_ACC_MEM) begin
			return K_ACCMEM;
		end else if (hi7 == OP_ADD_ACC || hi7 == OP_SUB_ACC || hi7 == OP_CMP_ACC) begin
			return K_ACCIMM;
		end else if (op == OP_JNE) begin
			return K_JNE;
		end else begin
			return K_UNKNOWN;
		end
	endfunction

	// Number of displacement bytes that a ModRM byte calls for.
	function automatic logic [1:0] disp_size(input byte_t modrm);
		unique case (modrm[7:6])
			2'd0:    return (modrm[2:0] == 3'd6) ? 2'd2 : 2'd0;
			2'd1:    return 2'd1;
			2'd2:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	// Number of immediate bytes of an immediate-to-memory opcode.
	function automatic logic [1:0] imm_size(input byte_t op);
		if ((op & 8'hFC) == OP_GRP_IRM) begin
			return (op[1:0] == 2'b01) ? 2'd2 : 2'd1;
		end
		return op[0] ? 2'd2 : 2'd1;
	endfunction

	// Total length, or zero while the ModRM byte is still missing.
	function automatic logic [2:0] instr_length(input byte_t op, input byte_t modrm,
		input logic have_modrm);
		unique case (op_kind(op))
			K_RMREG:  return have_modrm ? 3'(2 + disp_size(modrm)) : 3'd0;
			K_IMMRM:  return have_modrm ? 3'(2 + disp_size(modrm) + imm_size(op)) : 3'd0;
			K_IMMREG: return 3'(2 + op[3]);
			K_MEMACC: return 3'd3;
			K_ACCMEM: return 3'd3;
			K_ACCIMM: return 3'(2 + op[0]);
			K_JNE:    return 3'd2;
			default:  return 3'd1;
		endcase
	endfunction

endpackage

[design/xfd_front.sv]
// ----------------------------------------------------------------------------
// xfd_front: byte gatherer
// Collects code bytes into the current instruction, works out its length
// from the opcode and ModRM bytes, and pushes each complete instruction.
// ----------------------------------------------------------------------------
module xfd_front
	import xfd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_ready,
	input  byte_t         code_byte,
	input  queue_status_t q_status,
	output logic          push,
	output instr_t        push_instr
);

	localparam int IDX_BITS = $clog2(MAX_LEN);

	byte_t [MAX_LEN-1:0] held_q;
	logic [IDX_BITS-1:0] taken_q;

	logic       take;
	byte_t      op;
	byte_t      modrm;
	logic [2:0] len;
	logic       complete;

	// A byte is taken whenever the queue can hold a finished instruction.
	assign byte_ready = !q_status.full;
	assign take = byte_valid && byte_ready;

	// Length from the opcode and ModRM, with the arriving byte merged in.
	always_comb begin
		op = (taken_q == '0) ? code_byte : held_q[0];
		modrm = (taken_q == IDX_BITS'(1)) ? code_byte : held_q[1];
		len = instr_length(op, modrm, taken_q != '0);
		complete = (len != 3'd0) && ((3'(taken_q) + 3'd1) == len);
	end

	// The pushed instruction carries the arriving byte at its place.
	always_comb begin
		for (int i = 0; i < MAX_LEN; i++) begin
			push_instr.bytes[i] = (taken_q == IDX_BITS'(i)) ? code_byte : held_q[i];
		end
		push_instr.len = len;
		push = take && complete;
	end

	// Byte store; entries past the current count are never read.
	always_ff @(posedge clk) begin
		if (take) begin
			held_q[taken_q] <= code_byte;
		end
	end

	// Count of bytes gathered for the current instruction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
		end else if (take) begin
			if (complete) begin
				taken_q <= '0;
			end else begin
				taken_q <= taken_q + IDX_BITS'(1);
			end
		end
	end

	// The count never reaches the longest instruction length.
	assert property (@(posedge clk) disable iff (!arst_n) 3'(taken_q) < 3'(MAX_LEN))
		else $error("byte count ran past the longest instruction");

endmodule

[design/xfd_queue.sv]
// ----------------------------------------------------------------------------
// xfd_queue: instruction queue
// A short first-in first-out queue of gathered instructions that lets the
// gatherer and the decoder stall independently.
// ----------------------------------------------------------------------------
module xfd_queue
	import xfd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  instr_t        push_instr,
	input  logic          pop,
	output instr_t        head,
	output queue_status_t status
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	instr_t              slots_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign status.full = (count_q == CNT_BITS'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head = slots_q[rd_ptr_q];

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_instr;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

	// The gatherer never pushes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !status.full)
		else $error("push into a full instruction queue");

	// The decoder never pops an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !status.empty)
		else $error("pop from an empty instruction queue");

	// A queued instruction always has a length of one to six bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (head.len != 3'd0 && head.len <= 3'(MAX_LEN)))
		else $error("queued instruction has no valid length");

endmodule

[design/xfd_back.sv]
// ----------------------------------------------------------------------------
// xfd_back: field decoder
// Takes gathered instructions from the queue, splits them into their
// fields and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module xfd_back
	import xfd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t q_status,
	input  instr_t        head,
	output logic          pop,
	output logic          res_valid,
	input  logic          res_ready,
	output result_t       res
);

	logic    out_valid_q;
	result_t out_q;
	result_t dec;

	// Sign extension of one byte to a 16-bit word.
	function automatic logic [15:0] sx8(input byte_t b);
		return {{8{b[7]}}, b};
	endfunction

	// Field decode of the queue head.
	always_comb begin
		byte_t      op;
		byte_t      m;
		kind_t      kind;
		logic [1:0] ds;
		logic [2:0] ip;
		logic [2:0] hi;
		op = head.bytes[0];
		m = head.bytes[1];
		kind = op_kind(op);
		ds = disp_size(m);
		ip = 3'(2 + ds);
		hi = op[5:3];
		dec = '0;
		dec.mnemonic = MN_UNKNOWN;
		dec.form = FM_RM_REG;
		dec.length = head.len;
		unique case (kind)
			K_RMREG, K_IMMRM: begin
				dec.mode = m[7:6];
				dec.reg_field = m[5:3];
				dec.rm_field = m[2:0];
				dec.wide = op[0];
				if (ds == 2'd1) begin
					dec.displacement = sx8(head.bytes[2]);
				end else if (ds == 2'd2) begin
					dec.displacement = {head.bytes[3], head.bytes[2]};
				end
				if (kind == K_RMREG) begin
					dec.form = FM_RM_REG;
					dec.to_reg = op[1];
					priority if ((op & 8'hFC) == OP_MOV_RM) begin
						dec.mnemonic = MN_MOV;
					end else if (hi == OP_ADD_RM[5:3]) begin
						dec.mnemonic = MN_ADD;
					end else if (hi == OP_SUB_RM[5:3]) begin
						dec.mnemonic = MN_SUB;
					end else begin
						dec.mnemonic = MN_CMP;
					end
				end else begin
					dec.form = FM_IMM_RM;
					if ((op & 8'hFC) == OP_GRP_IRM) begin
						dec.sign_extend = op[1];
						priority if (m[5:3] == GRP_ADD) begin
							dec.mnemonic = MN_ADD;
						end else if (m[5:3] == GRP_SUB) begin
							dec.mnemonic = MN_SUB;
						end else if (m[5:3] == GRP_CMP) begin
							dec.mnemonic = MN_CMP;
						end else begin
							dec.mnemonic = MN_UNKNOWN;
						end
					end else begin
						dec.mnemonic = MN_MOV;
					end
					// Immediate after the displacement; byte data is sign
					// extended only for the group with both s and w set.
					if (imm_size(op) == 2'd2) begin
						dec.immediate = {head.bytes[ip + 3'd1], head.bytes[ip]};
					end else if ((op & 8'hFC) == OP_GRP_IRM && op[1] && op[0]) begin
						dec.immediate = sx8(head.bytes[ip]);
					end else begin
						dec.immediate = {8'h00, head.bytes[ip]};
					end
				end
			end
			K_IMMREG: begin
				dec.mnemonic = MN_MOV;
				dec.form = FM_IMM_REG;
				dec.wide = op[3];
				dec.to_reg = 1'b1;
				dec.reg_field = op[2:0];
				dec.immediate = op[3] ? {head.bytes[2], head.bytes[1]} :
					{8'h00, head.bytes[1]};
			end
			K_MEMACC, K_ACCMEM: begin
				dec.mnemonic = MN_MOV;
				dec.wide = op[0];
				dec.displacement = {head.bytes[2], head.bytes[1]};
				dec.form = (kind == K_MEMACC) ? FM_MEM_TO_ACC : FM_ACC_TO_MEM;
				dec.to_reg = (kind == K_MEMACC);
			end
			K_ACCIMM: begin
				dec.form = FM_ACC_IMM;
				dec.wide = op[0];
				dec.to_reg = 1'b1;
				priority if (hi == OP_ADD_ACC[5:3]) begin
					dec.mnemonic = MN_ADD;
				end else if (hi == OP_SUB_ACC[5:3]) begin
					dec.mnemonic = MN_SUB;
				end else begin
					dec.mnemonic = MN_CMP;
				end
				dec.immediate = op[0] ? {head.bytes[2], head.bytes[1]} :
					{8'h00, head.bytes[1]};
			end
			K_JNE: begin
				dec.mnemonic = MN_JNE;
				dec.form = FM_JUMP;
				dec.displacement = sx8(head.bytes[1]);
			end
			default: begin
				dec.length = head.len;
			end
		endcase
	end

	// Take the next instruction whenever the output register frees up.
	assign pop = !q_status.empty && (!out_valid_q || res_ready);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= dec;
		end
	end

	assign res_valid = out_valid_q;
	assign res = out_q;

endmodule

[design/x86_16_instruction_field_decoder.sv]
// ----------------------------------------------------------------------------
// x86_16_instruction_field_decoder: byte-serial 8086 instruction decoder
// Gathers an 8086 code stream into instructions and gives the decoded
// fields and the length of each complete instruction.
// ----------------------------------------------------------------------------
// The block takes one code byte per cycle on the slave side while s_tready
// is high and gives one result word per complete instruction on the master
// side, so it sustains one byte per cycle while the queue has room. A result
// word is registered first in the instruction queue and then in the output
// register before it is offered on the master side. The queue
// of QUEUE_DEPTH instructions sets how long the input
// keeps flowing while the output is stalled; once it is full, s_tready
// drops until the decoder frees a slot. Unknown opcodes give a one-byte
// result with every field but the length set to zero.
module x86_16_instruction_field_decoder
	import xfd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// code_byte [7:0]
	input  logic [7:0]                s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// mnemonic [2:0], form [5:3], wide [6], to_reg [7], sign_extend [8],
	// mode [10:9], reg_field [13:11], rm_field [16:14], displacement [32:17],
	// immediate [48:33], length [51:49], zero padding above
	output logic [OUT_BYTES_BITS-1:0] m_tdata
);

	queue_status_t q_status;
	logic          push;
	instr_t        push_instr;
	logic          pop;
	instr_t        head;
	result_t       res;

	// Byte gatherer.
	xfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_tvalid),
		.byte_ready (s_tready),
		.code_byte  (s_tdata),
		.q_status   (q_status),
		.push       (push),
		.push_instr (push_instr)
	);

	// Instruction queue.
	xfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_instr (push_instr),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// Field decoder and output register.
	xfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {{(OUT_BYTES_BITS - RESULT_BITS){1'b0}}, res};

endmodule
